// ----- hdl/ssp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the single-source shortest path block:
// beat layouts, register indexes, field widths and controller states.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int VIDX_W           = 6;
    localparam int VCNT_W           = 7;
    localparam int WGT_W            = 16;
    localparam int DIST_W           = 32;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 1024;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [VIDX_W-1:0] SOURCE_RESET = 6'd0;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [VIDX_W-1:0]        edge_from;
        logic [VIDX_W-1:0]        edge_to;
        logic signed [WGT_W-1:0]  edge_weight;
        logic                     last_edge;
    } edge_beat_t;

    typedef struct packed {
        logic [VIDX_W-1:0]        vertex_index;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic                     negative_cycle;
        logic                     last_result;
    } result_beat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_EREAD,
        ST_DREAD,
        ST_RELAX,
        ST_OREAD,
        ST_OLOAD
    } ssp_state_t;

endpackage

// ----- hdl/single_source_shortest_path.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Bellman-Ford shortest paths over a stored edge list, one distance memory
// with two read ports, relaxation one edge at a time.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-----------------------------
//   edge      | edge_valid / edge_stall    | edge_beat   (edge_beat_t)
//   result    | result_valid / result_stall| result_beat (result_beat_t)
//   config    | cfg_we                     | cfg_index, cfg_data
//
// edges load at one beat per cycle while edge_stall is low; beats beyond MAX_EDGES are dropped
// a run takes each stored edge, pass after pass, through an edge read and
// the read / add-compare / write-back sequence on the distance memory
// results then leave one beat per vertex while result_stall is low
// edge beats are taken again once the final result sits in the output register
// no clearing pass after reset: reached bits are flops cleared at each run
// ----------------------------------------------------------------------------
module single_source_shortest_path
#(
    parameter int MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ssp_pkg::MAX_EDGES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                edge_valid,
    output logic                                edge_stall,
    input  ssp_pkg::edge_beat_t                 edge_beat,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ssp_pkg::result_beat_t               result_beat,
    input  logic                                cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ssp_pkg::*;

    localparam int VA_W   = $clog2(MAX_VERTICES);
    localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = 2 * VIDX_W + WGT_W;
    localparam int EXT_W  = DIST_W + 1 - WGT_W;

    ssp_state_t                 state_reg;
    ssp_state_t                 state_next;
    logic [VCNT_W-1:0]          vcount_reg;
    logic [VIDX_W-1:0]          source_reg;
    logic [EC_W-1:0]            count_reg;
    logic [EC_W-1:0]            e_reg;
    logic [VCNT_W-1:0]          pass_reg;
    logic                       check_reg;
    logic                       neg_reg;
    logic [VCNT_W-1:0]          i_reg;
    logic [MAX_VERTICES-1:0]    reached_reg;
    logic                       result_valid_reg;
    result_beat_t               result_reg;

    logic [EDGE_W-1:0]          edge_mem [MAX_EDGES];
    logic [EDGE_W-1:0]          edge_rd_reg;
    logic signed [DIST_W-1:0]   dist_mem [MAX_VERTICES];
    logic signed [DIST_W-1:0]   dist_a_reg;
    logic signed [DIST_W-1:0]   dist_b_reg;

    logic [VCNT_W-1:0]          n_eff;
    logic                       edge_accept;
    logic                       edge_we;
    logic                       edge_re;
    logic                       store_ok;
    logic [VIDX_W-1:0]          u;
    logic [VIDX_W-1:0]          v;
    logic signed [WGT_W-1:0]    w;
    logic [VA_W-1:0]            u_idx;
    logic [VA_W-1:0]            v_idx;
    logic [VA_W-1:0]            i_idx;
    logic [VA_W-1:0]            src_idx;
    logic                       edge_live;
    logic signed [DIST_W:0]     sum;
    logic signed [DIST_W-1:0]   cand;
    logic                       lower;
    logic                       pass_end;
    logic                       src_ok;
    logic                       out_free;
    logic                       out_last;
    logic                       dist_re;
    logic [VA_W-1:0]            dist_ra;
    logic                       dist_we;
    logic [VA_W-1:0]            dist_wa;
    logic signed [DIST_W-1:0]   dist_wd;
    logic                       result_load;

    // effective vertex count
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = VCNT_W'(1);
        end
        else if (vcount_reg > VCNT_W'(MAX_VERTICES))
        begin
            n_eff = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    assign edge_accept = edge_valid && !edge_stall;
    assign store_ok    = count_reg < EC_W'(MAX_EDGES);

    assign u       = edge_rd_reg[EDGE_W-1 -: VIDX_W];
    assign v       = edge_rd_reg[WGT_W +: VIDX_W];
    assign w       = signed'(edge_rd_reg[WGT_W-1:0]);
    assign u_idx   = u[VA_W-1:0];
    assign v_idx   = v[VA_W-1:0];
    assign i_idx   = i_reg[VA_W-1:0];
    assign src_idx = source_reg[VA_W-1:0];

    assign edge_live = ({1'b0, u} < n_eff) && ({1'b0, v} < n_eff) && reached_reg[u_idx];

    // saturating candidate distance
    assign sum = {dist_a_reg[DIST_W-1], dist_a_reg} + {{EXT_W{w[WGT_W-1]}}, w};

    always_comb
    begin
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end
    end

    assign lower    = edge_live && (!reached_reg[v_idx] || (cand < dist_b_reg));
    assign pass_end = (e_reg + EC_W'(1)) == count_reg;
    assign src_ok   = {1'b0, source_reg} < n_eff;
    assign out_free = !result_valid_reg || !result_stall;
    assign out_last = (i_reg + VCNT_W'(1)) == n_eff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (edge_accept && edge_beat.last_edge)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:  state_next = ST_EREAD;
            ST_EREAD: state_next = ST_DREAD;
            ST_DREAD: state_next = ST_RELAX;
            ST_RELAX:
            begin
                state_next = (pass_end && check_reg) ? ST_OREAD : ST_EREAD;
            end
            ST_OREAD: state_next = ST_OLOAD;
            ST_OLOAD:
            begin
                if (out_free)
                begin
                    state_next = out_last ? ST_LOAD : ST_OREAD;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb
    begin
        edge_stall  = 1'b1;
        edge_re     = 1'b0;
        dist_re     = 1'b0;
        dist_ra     = u_idx;
        dist_we     = 1'b0;
        dist_wa     = v_idx;
        dist_wd     = cand;
        result_load = 1'b0;
        unique case (state_reg)
            ST_LOAD:  edge_stall = 1'b0;
            ST_INIT:
            begin
                dist_we = src_ok;
                dist_wa = src_idx;
                dist_wd = '0;
            end
            ST_EREAD: edge_re = 1'b1;
            ST_DREAD: dist_re = 1'b1;
            ST_RELAX: dist_we = lower && !check_reg;
            ST_OREAD:
            begin
                dist_re = 1'b1;
                dist_ra = i_idx;
            end
            ST_OLOAD: result_load = out_free;
            default:  edge_stall = 1'b1;
        endcase
    end

    assign edge_we = edge_accept && store_ok;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            vcount_reg       <= VCOUNT_RESET;
            source_reg       <= SOURCE_RESET;
            count_reg        <= '0;
            e_reg            <= '0;
            pass_reg         <= '0;
            check_reg        <= 1'b0;
            neg_reg          <= 1'b0;
            i_reg            <= '0;
            reached_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VERTEX_COUNT:  vcount_reg <= cfg_data[VCNT_W-1:0];
                    REG_SOURCE_VERTEX: source_reg <= cfg_data[VIDX_W-1:0];
                    default:           vcount_reg <= vcount_reg;
                endcase
            end

            if (edge_we)
            begin
                count_reg <= count_reg + EC_W'(1);
            end

            if (state_reg == ST_INIT)
            begin
                reached_reg <= src_ok ? (MAX_VERTICES'(1) << src_idx) : '0;
                e_reg     <= '0;
                pass_reg  <= VCNT_W'(1);
                check_reg <= n_eff == VCNT_W'(1);
                neg_reg   <= 1'b0;
            end

            if (state_reg == ST_RELAX)
            begin
                if (lower && !check_reg)
                begin
                    reached_reg[v_idx] <= 1'b1;
                end
                if (lower && check_reg)
                begin
                    neg_reg <= 1'b1;
                end
                if (pass_end)
                begin
                    e_reg <= '0;
                    i_reg <= '0;
                    if (!check_reg)
                    begin
                        pass_reg  <= pass_reg + VCNT_W'(1);
                        check_reg <= (pass_reg + VCNT_W'(1)) == n_eff;
                    end
                end
                else
                begin
                    e_reg <= e_reg + EC_W'(1);
                end
            end

            if (result_load)
            begin
                if (out_last)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    i_reg <= i_reg + VCNT_W'(1);
                end
            end

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[count_reg[EA_W-1:0]] <= {edge_beat.edge_from, edge_beat.edge_to,
                                              edge_beat.edge_weight};
        end
        if (edge_re)
        begin
            edge_rd_reg <= edge_mem[e_reg[EA_W-1:0]];
        end
    end

    // distance memory
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        if (dist_re)
        begin
            dist_a_reg <= dist_mem[dist_ra];
            dist_b_reg <= dist_mem[v_idx];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.vertex_index   <= i_reg[VIDX_W-1:0];
            result_reg.distance       <= reached_reg[i_idx] ? dist_a_reg : '0;
            result_reg.reachable      <= reached_reg[i_idx];
            result_reg.negative_cycle <= neg_reg;
            result_reg.last_result    <= out_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_reg;

`ifndef SYNTHESIS
    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_beat.last_result)
            |-> ((VCNT_W'(result_beat.vertex_index) + VCNT_W'(1)) == n_eff))
        else $error("last result not on final vertex");

    a_last_edge_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_accept && edge_beat.last_edge) |=> (state_reg == ST_INIT))
        else $error("final edge did not start a run");

    a_relax_from_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (dist_we && state_reg == ST_RELAX) |-> (reached_reg[u_idx] && !check_reg))
        else $error("distance written from unreached tail or in check pass");

    a_result_from_output_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == ST_OLOAD))
        else $error("result beat raised outside output phase");
`endif

endmodule

// ----- tb/single_source_shortest_path_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path_tb
// Self-checking bench for the shortest path block. Edge beats are fed from a
// queue by a clocked driver; every accepted edge updates a local copy of the
// edge store and, on the final edge, the distances are worked out here and
// queued. A clocked monitor compares each result beat against that queue.
// Directed graphs cover the field extremes, range corner cases and negative
// cycles, then random graphs follow.
// ----------------------------------------------------------------------------
module single_source_shortest_path_tb;

    import ssp_pkg::*;

    localparam int MAX_V       = MAX_VERTICES_DEF;
    localparam int MAX_E       = MAX_EDGES_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_EDGES = 105;

    typedef struct packed {
        edge_beat_t beat;
        logic [3:0] gap;
    } feed_item_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  edge_valid   = 1'b0;
    logic                  edge_stall;
    edge_beat_t            edge_beat    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_beat_t          result_beat;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = REG_VERTEX_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // local copy of the block state
    logic [VCNT_W-1:0]       vertex_count_reg = VCOUNT_RESET;
    logic [VIDX_W-1:0]       source_reg       = SOURCE_RESET;
    logic [VIDX_W-1:0]       graph_from   [MAX_E];
    logic [VIDX_W-1:0]       graph_to     [MAX_E];
    logic signed [WGT_W-1:0] graph_weight [MAX_E];
    int                      edge_count = 0;
    logic signed [DIST_W-1:0] dist_table [MAX_V];
    bit                      reach_bits [MAX_V];

    feed_item_t   edge_feed[$];
    result_beat_t predicted_vertices[$];

    bit calm         = 1'b0;
    int gap_count    = 0;
    int stall_left   = 0;
    int result_hold  = 0;
    int cycle_count  = 0;
    int error_count  = 0;
    int edge_beats   = 0;
    int result_beats = 0;
    int graphs_solved = 0;
    int random_items = 0;

    single_source_shortest_path dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .edge_valid   (edge_valid),
        .edge_stall   (edge_stall),
        .edge_beat    (edge_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic int clamp_vertices(int vc);
        if (vc < 1)
            return 1;
        if (vc > MAX_V)
            return MAX_V;
        return vc;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // one sweep over the stored edges, lowering heads when apply is set
    function automatic bit relax_pass(int n, bit apply);
        bit     lowered;
        int     u;
        int     v;
        longint cand;
        lowered = 1'b0;
        for (int e = 0; e < edge_count; e++)
        begin
            u = graph_from[e];
            v = graph_to[e];
            if (u >= n || v >= n || !reach_bits[u])
                continue;
            cand = longint'(dist_table[u]) + longint'(graph_weight[e]);
            if (cand > longint'(DIST_MAX))
                cand = longint'(DIST_MAX);
            if (cand < longint'(DIST_MIN))
                cand = longint'(DIST_MIN);
            if (!reach_bits[v] || cand < longint'(dist_table[v]))
            begin
                lowered = 1'b1;
                if (apply)
                begin
                    dist_table[v] = cand[DIST_W-1:0];
                    reach_bits[v] = 1'b1;
                end
            end
        end
        return lowered;
    endfunction

    task automatic solve_shortest_paths();
        int           n;
        bit           neg;
        result_beat_t r;
        n = clamp_vertices(vertex_count_reg);
        for (int i = 0; i < MAX_V; i++)
        begin
            reach_bits[i] = 1'b0;
            dist_table[i] = '0;
        end
        if (source_reg < n)
            reach_bits[source_reg] = 1'b1;
        for (int p = 1; p < n; p++)
            void'(relax_pass(n, 1'b1));
        neg = relax_pass(n, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            r.vertex_index   = VIDX_W'(i);
            r.distance       = reach_bits[i] ? dist_table[i] : '0;
            r.reachable      = reach_bits[i];
            r.negative_cycle = neg;
            r.last_result    = (i == n - 1);
            predicted_vertices.push_back(r);
        end
        edge_count = 0;
        graphs_solved++;
    endtask

    task automatic accept_edge(edge_beat_t b);
        if (edge_count < MAX_E)
        begin
            graph_from[edge_count]   = b.edge_from;
            graph_to[edge_count]     = b.edge_to;
            graph_weight[edge_count] = b.edge_weight;
            edge_count++;
        end
        edge_beats++;
        if (b.last_edge)
            solve_shortest_paths();
    endtask

    task automatic check_result(result_beat_t got);
        result_beat_t want;
        result_beats++;
        if (predicted_vertices.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result beat for vertex %0d",
                                      got.vertex_index));
            return;
        end
        want = predicted_vertices.pop_front();
        if (got.vertex_index !== want.vertex_index)
            report_mismatch($sformatf("vertex_index %0d, want %0d",
                                      got.vertex_index, want.vertex_index));
        if (got.distance !== want.distance)
            report_mismatch($sformatf("vertex %0d distance %0d, want %0d",
                                      want.vertex_index, got.distance, want.distance));
        if (got.reachable !== want.reachable)
            report_mismatch($sformatf("vertex %0d reachable %b, want %b",
                                      want.vertex_index, got.reachable, want.reachable));
        if (got.negative_cycle !== want.negative_cycle)
            report_mismatch($sformatf("vertex %0d negative_cycle %b, want %b",
                                      want.vertex_index, got.negative_cycle,
                                      want.negative_cycle));
        if (got.last_result !== want.last_result)
            report_mismatch($sformatf("vertex %0d last_result %b, want %b",
                                      want.vertex_index, got.last_result,
                                      want.last_result));
    endtask

    // edge driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (edge_valid && !edge_stall)
                accept_edge(edge_beat);
            if (!edge_valid || !edge_stall)
            begin
                if (edge_feed.size() == 0)
                    edge_valid <= 1'b0;
                else if (gap_count < edge_feed[0].gap)
                begin
                    gap_count  <= gap_count + 1;
                    edge_valid <= 1'b0;
                end
                else
                begin
                    edge_beat  <= edge_feed[0].beat;
                    edge_valid <= 1'b1;
                    gap_count  <= 0;
                    edge_feed.delete(0);
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                check_result(result_beat);
                result_hold = draw_wait();
                stall_left   <= result_hold;
                result_stall <= (result_hold != 0);
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= (stall_left > 1);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result beats still due",
                     cycle_count, predicted_vertices.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        if (idx == REG_VERTEX_COUNT)
            vertex_count_reg = value[VCNT_W-1:0];
        else
            source_reg = value[VIDX_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int vc, int src);
        write_reg(REG_VERTEX_COUNT, vc);
        write_reg(REG_SOURCE_VERTEX, src);
        @(negedge clk);
    endtask

    task automatic queue_edge(int f, int t, int wv, bit last);
        feed_item_t item;
        item.beat.edge_from   = f[VIDX_W-1:0];
        item.beat.edge_to     = t[VIDX_W-1:0];
        item.beat.edge_weight = wv[WGT_W-1:0];
        item.beat.last_edge   = last;
        item.gap              = 4'(draw_wait());
        edge_feed.push_back(item);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (edge_feed.size() != 0 || edge_valid || predicted_vertices.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // mostly edges hanging off vertices already reached, some stray ones
    task automatic random_graph();
        int vc;
        int src;
        int n;
        int count;
        int pick;
        int f;
        int t;
        int wv;
        int frontier[$];
        pick = $urandom_range(0, 15);
        if (pick == 0)
            vc = 0;
        else if (pick == 1)
            vc = $urandom_range(65, 127);
        else if (pick < 5)
            vc = $urandom_range(13, 64);
        else
            vc = $urandom_range(2, 12);
        n = clamp_vertices(vc);
        if ($urandom_range(0, 7) == 0)
            src = $urandom_range(0, 127);
        else
            src = $urandom_range(0, n - 1);
        calm = ($urandom_range(0, 3) == 0);
        set_config(vc, src);
        count = $urandom_range(1, 12);
        frontier.push_back(src % 64);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                f = frontier[$urandom_range(0, frontier.size() - 1)];
                t = $urandom_range(0, n - 1);
                frontier.push_back(t);
            end
            else
            begin
                f = $urandom_range(0, 63);
                t = $urandom_range(0, 63);
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
                wv = int'($urandom_range(0, 120)) - 20;
            else if (pick < 8)
                wv = -int'($urandom_range(1, 60));
            else
                wv = $urandom_range(0, 65535);
            queue_edge(f, t, wv, k == count - 1);
        end
        random_items += count;
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // settings from reset, field extremes
        queue_edge(0, 1, 32767, 1'b0);
        queue_edge(1, 2, -32768, 1'b0);
        queue_edge(63, 0, 5, 1'b0);
        queue_edge(2, 63, 0, 1'b1);
        wait_idle();

        // endpoints out of range and a reachable negative cycle
        set_config(5, 2);
        queue_edge(2, 3, 7, 1'b0);
        queue_edge(2, 5, 1, 1'b0);
        queue_edge(6, 3, -1, 1'b0);
        queue_edge(3, 4, -3, 1'b0);
        queue_edge(4, 3, 1, 1'b1);
        wait_idle();

        // zero vertices acts as one, negative self loop on the source
        set_config(0, 0);
        queue_edge(0, 0, -1, 1'b1);
        wait_idle();

        // count above the maximum acts as the maximum
        set_config(127, 63);
        queue_edge(63, 0, -32768, 1'b0);
        queue_edge(0, 62, 100, 1'b1);
        wait_idle();

        // source outside the graph reaches nothing
        set_config(3, 5);
        queue_edge(5, 0, 4, 1'b0);
        queue_edge(0, 1, 4, 1'b1);
        wait_idle();

        // single last edge, from an unreached vertex into the source
        set_config(2, 1);
        queue_edge(0, 1, -7, 1'b1);
        wait_idle();

        while (random_items < RANDOM_EDGES)
            random_graph();

        repeat (20) @(posedge clk);
        if (predicted_vertices.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      predicted_vertices.size()));

        $display("covered %0d graphs: %0d edge beats in, %0d result beats checked",
                 graphs_solved, edge_beats, result_beats);
        $display("%0d mismatches over %0d cycles", error_count, cycle_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
